FILE: src/gsh_pkg.sv
// Shared types and constants for the gshare predictor with branch target buffer.
package gsh_pkg;

    // Address width of the fetch stream.
    localparam int unsigned PC_W = 64;

    // Command codes carried by the command field.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Sequential fetch step.
    localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

    // Two-bit saturating counter.
    typedef logic [1:0] t_ctr;
    localparam t_ctr CTR_MIN        = 2'd0;
    localparam t_ctr CTR_MAX        = 2'd3;
    localparam t_ctr CTR_WEAK_TAKEN = 2'd2;

    // One branch target buffer entry.
    typedef struct packed {
        logic            valid;
        logic            cond;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
    } t_btb_entry;

    localparam int unsigned BTB_ENTRY_W = $bits(t_btb_entry);

endpackage

FILE: src/gsh_ram.sv
// Single-port-write, single-port-read table with registered read, write bypass and clearing pass.
module gsh_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic                     o_busy
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];

    logic [WIDTH-1:0] r_q;
    logic             r_byp;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;

    // The clearing pass owns the write port until every entry holds zero.
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    // Storage array with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // A write at the same edge as a read to the same entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_q;

    // Sweep counter for the clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_clr_busy;

endmodule

FILE: src/gshare_predictor_with_btb_unit.sv
// Top level of the gshare branch predictor with direct-mapped branch target buffer.
// Flow: a predict beat is registered into stage one together with its table reads,
// then into the output register, waiting in stage one while that register stalls.
// Throughput: one beat per cycle, predict or update, while o_in_ready is high;
// updates produce no result beat. Reset: a clearing pass zeroes the counter table
// and BTB entries, and o_in_ready stays low while it runs.
module gshare_predictor_with_btb_unit #(
    parameter int unsigned HISTORY_BITS = 8,
    parameter int unsigned BTB_ENTRIES  = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_command,
    input  logic [gsh_pkg::PC_W-1:0] i_pc,
    input  logic                    i_taken,
    input  logic                    i_is_conditional,
    input  logic [gsh_pkg::PC_W-1:0] i_branch_target,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [gsh_pkg::PC_W-1:0] o_next_pc
);

    import gsh_pkg::*;

    localparam int unsigned PHT_ENTRIES = 2 ** HISTORY_BITS;
    localparam int unsigned BTB_AW      = $clog2(BTB_ENTRIES);

    // Global history and pipeline registers.
    logic [HISTORY_BITS-1:0] r_hist;
    logic                    r_s1_valid;
    logic                    r_s1_cmd;
    logic [PC_W-1:0]         r_s1_pc;
    logic                    r_s1_taken;
    logic                    r_s1_cond;
    logic [PC_W-1:0]         r_s1_target;
    logic [HISTORY_BITS-1:0] r_s1_pidx;
    logic [BTB_AW-1:0]       r_s1_bidx;
    logic                    r_o_valid;
    logic [PC_W-1:0]         r_o_next_pc;

    logic                    accept;
    logic                    busy;
    logic                    pht_busy;
    logic                    btb_busy;
    logic [HISTORY_BITS-1:0] pht_ridx;
    logic [BTB_AW-1:0]       btb_ridx;
    t_ctr                    ctr;
    t_ctr                    n_ctr;
    logic [BTB_ENTRY_W-1:0]  btb_rd_data;
    t_btb_entry              entry;
    t_btb_entry              wr_entry;
    logic                    hit;
    logic                    use_target;
    logic [PC_W-1:0]         n_next_pc;
    logic                    s1_go;
    logic                    tbl_wr_en;

    assign busy   = pht_busy || btb_busy;
    assign accept = i_in_valid && o_in_ready;

    // Table indexes for the incoming beat.
    assign pht_ridx = i_pc[HISTORY_BITS+1:2] ^ r_hist;
    assign btb_ridx = i_pc[BTB_AW+1:2];

    // Stage one moves on unless a prediction finds the output register full and stalled.
    assign s1_go = r_s1_valid &&
                   ((r_s1_cmd == CMD_UPDATE) || !r_o_valid || i_out_ready);
    assign tbl_wr_en  = s1_go && (r_s1_cmd == CMD_UPDATE);
    assign o_in_ready = !busy && (!r_s1_valid || s1_go);

    // Counter table.
    gsh_ram #(
        .DEPTH (PHT_ENTRIES),
        .WIDTH ($bits(t_ctr))
    ) u_pht (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (pht_ridx),
        .o_rd_data (ctr),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_s1_pidx),
        .i_wr_data (n_ctr),
        .o_busy    (pht_busy)
    );

    // Branch target buffer.
    gsh_ram #(
        .DEPTH (BTB_ENTRIES),
        .WIDTH (BTB_ENTRY_W)
    ) u_btb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (btb_ridx),
        .o_rd_data (btb_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_s1_bidx),
        .i_wr_data (wr_entry),
        .o_busy    (btb_busy)
    );

    // Prediction from the read entry and counter.
    always_comb begin
        entry      = t_btb_entry'(btb_rd_data);
        hit        = entry.valid && (entry.tag == r_s1_pc);
        use_target = hit && (!entry.cond || (ctr >= CTR_WEAK_TAKEN));
        n_next_pc  = use_target ? entry.target : (r_s1_pc + PC_STEP);
    end

    // Saturating counter training and the new BTB entry.
    always_comb begin
        if (r_s1_taken) begin
            n_ctr = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
        end else begin
            n_ctr = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
        end
        wr_entry.valid  = 1'b1;
        wr_entry.cond   = r_s1_cond;
        wr_entry.tag    = r_s1_pc;
        wr_entry.target = r_s1_target;
    end

    // Global history takes the outcome of each update in arrival order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (accept && (i_command == CMD_UPDATE)) begin
            r_hist <= {r_hist[HISTORY_BITS-2:0], i_taken};
        end
    end

    // Stage one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd    <= i_command;
            r_s1_pc     <= i_pc;
            r_s1_taken  <= i_taken;
            r_s1_cond   <= i_is_conditional;
            r_s1_target <= i_branch_target;
            r_s1_pidx   <= pht_ridx;
            r_s1_bidx   <= btb_ridx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && (r_s1_cmd == CMD_PREDICT)) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && (r_s1_cmd == CMD_PREDICT)) begin
            r_o_next_pc <= n_next_pc;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_next_pc   = r_o_next_pc;

`ifndef NO_ASSERTIONS
    // An update leaving stage one never creates a result beat.
    a_update_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_cmd == CMD_UPDATE))
        |=> (r_o_valid == $past(r_o_valid && !i_out_ready)))
        else $error("update produced a result beat");

    // A prediction leaving stage one is shown at the next edge.
    a_predict_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_cmd == CMD_PREDICT)) |=> r_o_valid)
        else $error("prediction lost");

    // History takes the outcome of an accepted update.
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_UPDATE)) |=> (r_hist[0] == $past(i_taken)))
        else $error("history did not take the outcome");

    // No table write and no pending item while the clearing pass runs.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!tbl_wr_en && !r_s1_valid))
        else $error("table activity during clearing pass");
`endif

endmodule

FILE: tb/sv/tb_gshare_predictor_with_btb_unit.sv
// Self-checking testbench for the gshare branch predictor with branch target buffer.
module tb_gshare_predictor_with_btb_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gsh_pkg::*;

    localparam int unsigned HIST_W    = 8;
    localparam int unsigned PHT_N     = 1 << HIST_W;
    localparam int unsigned BTB_N     = 1024;
    localparam int unsigned BTB_IDX_W = $clog2(BTB_N);
    localparam int unsigned N_RANDOM  = 500;
    localparam int unsigned POOL_N    = 16;
    localparam int unsigned HOLD_LEN  = 150;
    localparam int unsigned HOLD_AT   = 100;
    localparam int unsigned DRAIN_LEN = 8;
    localparam logic [PC_W-1:0] ALL_ONES = '1;

    logic            i_clk;
    logic            i_rst_n          = 1'b0;
    logic            i_in_valid       = 1'b0;
    logic            o_in_ready;
    logic            i_command        = CMD_PREDICT;
    logic [PC_W-1:0] i_pc             = '0;
    logic            i_taken          = 1'b0;
    logic            i_is_conditional = 1'b0;
    logic [PC_W-1:0] i_branch_target  = '0;
    logic            o_out_valid;
    logic            i_out_ready      = 1'b0;
    logic [PC_W-1:0] o_next_pc;

    gshare_predictor_with_btb_unit #(
        .HISTORY_BITS(HIST_W),
        .BTB_ENTRIES (BTB_N)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_pc            (i_pc),
        .i_taken         (i_taken),
        .i_is_conditional(i_is_conditional),
        .i_branch_target (i_branch_target),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_next_pc       (o_next_pc)
    );

    // Shadow copy of the predictor tables.
    logic [HIST_W-1:0] shadow_ghist = '0;
    t_ctr              shadow_pht [PHT_N] = '{default: CTR_MIN};
    t_btb_entry        shadow_btb [BTB_N] = '{default: '0};

    // Next fetch addresses still owed by the block, oldest first.
    logic [PC_W-1:0] next_pc_q [$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned predict_count  = 0;
    int unsigned update_count   = 0;
    int unsigned redirect_count = 0;

    // One row of the directed sequence; typed rows carry a next_pc known in advance.
    typedef struct packed {
        logic            cmd;
        logic [PC_W-1:0] pc;
        logic            taken;
        logic            cond;
        logic [PC_W-1:0] target;
        logic [7:0]      reps;
        logic            typed;
        logic [PC_W-1:0] want;
    } t_branch_row;

    localparam int unsigned N_ROWS = 19;
    t_branch_row branch_rows [N_ROWS] = '{
        // Cold tables: every predict falls through, including the wrap at the top.
        '{CMD_PREDICT, 64'h0, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1, 64'h4},
        '{CMD_PREDICT, ALL_ONES, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1, 64'h3},
        '{CMD_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1, 64'h0},
        // Unconditional entry hits regardless of the counter; update fields are ignored.
        '{CMD_UPDATE, 64'h100, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_F000, 8'd1, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'h100, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1, 64'hFFFF_FFFF_FFFF_F000},
        '{CMD_PREDICT, 64'h100, 1'b1, 1'b1, ALL_ONES, 8'd1, 1'b1, 64'hFFFF_FFFF_FFFF_F000},
        // Same BTB slot, different tag.
        '{CMD_PREDICT, 64'h1100, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1, 64'h1104},
        // Train a conditional branch up to saturation, then past it.
        '{CMD_UPDATE, 64'h240, 1'b1, 1'b1, 64'h8000, 8'd10, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'h240, 1'b0, 1'b0, 64'h0, 8'd1, 1'b0, 64'h0},
        '{CMD_UPDATE, 64'h240, 1'b1, 1'b1, 64'h8000, 8'd2, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'h240, 1'b0, 1'b0, 64'h0, 8'd1, 1'b0, 64'h0},
        // Train it back down to strongly not taken and hold it there.
        '{CMD_UPDATE, 64'h240, 1'b0, 1'b1, 64'h8000, 8'd10, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'h240, 1'b0, 1'b0, 64'h0, 8'd1, 1'b0, 64'h0},
        // Unconditional entries at both ends of the address space.
        '{CMD_UPDATE, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 1'b0, 64'h0123_4567_89AB_CDEF,
          8'd1, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1,
          64'h0123_4567_89AB_CDEF},
        '{CMD_UPDATE, 64'h0, 1'b0, 1'b0, ALL_ONES, 8'd1, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'h0, 1'b0, 1'b0, 64'h0, 8'd1, 1'b1, ALL_ONES},
        // Conditional entry at the top of the BTB index range.
        '{CMD_UPDATE, 64'h3FFC, 1'b1, 1'b1, 64'hAAAA_5555_AAAA_5555, 8'd1, 1'b0, 64'h0},
        '{CMD_PREDICT, 64'h3FFC, 1'b0, 1'b0, 64'h0, 8'd1, 1'b0, 64'h0}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Predict or train the shadow tables for one accepted beat.
    task automatic resolve_branch(input logic cmd, input logic [PC_W-1:0] pc,
                                  input logic tk, input logic cnd,
                                  input logic [PC_W-1:0] tgt,
                                  input logic typed, input logic [PC_W-1:0] want);
        logic [HIST_W-1:0]    pi;
        logic [BTB_IDX_W-1:0] bi;
        t_ctr                 ctr;
        pi  = pc[HIST_W+1:2] ^ shadow_ghist;
        bi  = pc[BTB_IDX_W+1:2];
        ctr = shadow_pht[pi];
        if (cmd == CMD_PREDICT) begin
            predict_count++;
            if (shadow_btb[bi].valid && shadow_btb[bi].tag == pc &&
                (!shadow_btb[bi].cond || ctr >= CTR_WEAK_TAKEN)) begin
                redirect_count++;
                next_pc_q.push_back(typed ? want : shadow_btb[bi].target);
            end else begin
                next_pc_q.push_back(typed ? want : pc + PC_STEP);
            end
        end else begin
            update_count++;
            if (tk && ctr != CTR_MAX)
                shadow_pht[pi] = ctr + 2'd1;
            else if (!tk && ctr != CTR_MIN)
                shadow_pht[pi] = ctr - 2'd1;
            shadow_ghist = {shadow_ghist[HIST_W-2:0], tk};
            shadow_btb[bi] = '{valid: 1'b1, cond: cnd, tag: pc, target: tgt};
        end
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(input logic cmd, input logic [PC_W-1:0] pc,
                             input logic tk, input logic cnd,
                             input logic [PC_W-1:0] tgt,
                             input logic typed, input logic [PC_W-1:0] want);
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_pc             <= pc;
        i_taken          <= tk;
        i_is_conditional <= cnd;
        i_branch_target  <= tgt;
        do @(posedge i_clk); while (!o_in_ready);
        resolve_branch(cmd, pc, tk, cnd, tgt, typed, want);
    endtask

    // Random pause between beats: mostly none, sometimes short, rarely long.
    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        n = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Let everything owed drain with the input idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (next_pc_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [PC_W-1:0] rand_pc64();
        return {$urandom, $urandom};
    endfunction

    // Result side: compare every accepted beat with the oldest expected next_pc.
    initial begin
        logic [PC_W-1:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                results_seen++;
                if (next_pc_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: next_pc beat %h with none expected", $time, o_next_pc);
                end else begin
                    want = next_pc_q.pop_front();
                    if (o_next_pc !== want) begin
                        mismatch_count++;
                        $display("%0t: next_pc mismatch: expected %h, actual %h",
                                 $time, want, o_next_pc);
                    end
                end
            end
        end
    end

    // Result side readiness: random runs of stalls and open stretches, one long hold.
    initial begin
        int unsigned run_left;
        int unsigned r;
        logic        level;
        bit          held;
        run_left = 0;
        level    = 1'b0;
        held     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held     = 1'b1;
                level    = 1'b0;
                run_left = HOLD_LEN;
            end else if (run_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 8);
                end else if (r < 65) begin
                    level    = 1'b1;
                    run_left = $urandom_range(20, 60);
                end else if (r < 90) begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 3);
                end else begin
                    level    = 1'b0;
                    run_left = $urandom_range(8, 40);
                end
            end
            i_out_ready <= level;
            run_left--;
        end
    end

    // Input side: reset, directed rows, then random traffic.
    initial begin
        logic [PC_W-1:0] pc_pool [POOL_N];
        logic [PC_W-1:0] pc;
        logic            cmd;
        int unsigned     r;
        for (int k = 0; k < POOL_N; k++)
            pc_pool[k] = rand_pc64();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; the block's clearing pass holds off the first beat.
        foreach (branch_rows[k]) begin
            for (int j = 0; j < branch_rows[k].reps; j++) begin
                send_beat(branch_rows[k].cmd, branch_rows[k].pc, branch_rows[k].taken,
                          branch_rows[k].cond, branch_rows[k].target,
                          branch_rows[k].typed, branch_rows[k].want);
                sender_gap();
            end
        end
        drain_results();

        // Random traffic: mostly a small set of recurring branches so the BTB hits.
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2)
                drain_results();
            cmd = $urandom_range(0, 1) ? CMD_UPDATE : CMD_PREDICT;
            r   = $urandom_range(0, 9);
            if (r < 7)
                pc = pc_pool[$urandom_range(0, POOL_N - 1)];
            else if (r == 7)
                pc = pc_pool[$urandom_range(0, POOL_N - 1)] ^
                     (64'h1 << $urandom_range(BTB_IDX_W + 2, PC_W - 1));
            else
                pc = rand_pc64();
            send_beat(cmd, pc, $urandom_range(0, 9) < 6, $urandom_range(0, 3) != 0,
                      rand_pc64(), 1'b0, '0);
            sender_gap();
        end

        // Wait for the last results and watch for strays.
        drain_results();
        repeat (DRAIN_LEN) @(posedge i_clk);

        $display("Covered %0d predict and %0d update beats; %0d predicts redirected to a BTB target.",
                 predict_count, update_count, redirect_count);
        $display("Checked %0d next_pc beats, %0d mismatching.", results_seen, mismatch_count);
        if (mismatch_count == 0 && next_pc_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
